// File: sv/dkp_pkg.sv
// Shared types and constants for the two-key debounce block.
`default_nettype none

package dkp_pkg;

	// Field widths
	localparam int unsigned TimeW = 32;
	localparam int unsigned CfgW  = 16;
	localparam int unsigned InW   = 40;
	localparam int unsigned OutW  = 8;

	// Configuration register indexes
	typedef enum logic [1:0] {
		REG_PRESS_CONFIRM   = 2'd0,
		REG_RELEASE_CONFIRM = 2'd1,
		REG_HOLD            = 2'd2,
		REG_STARTUP_DELAY   = 2'd3
	} reg_idx_t;

	// Reset values of the configuration registers
	localparam logic [CfgW-1:0] PressConfirmRst   = 16'd50;
	localparam logic [CfgW-1:0] ReleaseConfirmRst = 16'd50;
	localparam logic [CfgW-1:0] HoldRst           = 16'd900;
	localparam logic [CfgW-1:0] StartupDelayRst   = 16'd300;

	// Key phase machine states
	typedef enum logic [2:0] {
		KEY_IDLE       = 3'd0,
		KEY_PRESS_WAIT = 3'd1,
		KEY_DOWN       = 3'd2,
		KEY_LONG       = 3'd3,
		KEY_REL_WAIT   = 3'd4
	} key_phase_t;

	// Charge pin status codes
	typedef enum logic [1:0] {
		CHG_STABLE_LOW  = 2'd0,
		CHG_STABLE_HIGH = 2'd1,
		CHG_CHANGING    = 2'd2
	} chg_status_t;

	// Timing settings handed to each key machine
	typedef struct packed {
		logic [CfgW-1:0] press_confirm;
		logic [CfgW-1:0] release_confirm;
		logic [CfgW-1:0] hold;
	} key_cfg_t;

	// What one key machine reports for the word in flight
	typedef struct packed {
		logic pressed_next;
		logic short_press;
		logic long_hold;
	} key_evt_t;

endpackage

`default_nettype wire

// File: sv/dkp_key.sv
// Debounce and press/hold phase machine for one key.
`default_nettype none

module dkp_key
	import dkp_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             step,
	input  wire logic             level,
	input  wire logic [TimeW-1:0] now_ms,
	input  wire key_cfg_t         cfg,
	output key_evt_t              evt
);

	key_phase_t       phase_q;
	key_phase_t       phase_next;
	logic [TimeW-1:0] stamp_q;
	logic [TimeW-1:0] stamp_next;
	logic [TimeW-1:0] dt;

	// Elapsed time since the stamp, wrapping modulo 2^32.
	assign dt = now_ms - stamp_q;

	// Next phase and stamp.
	always_comb begin
		phase_next = phase_q;
		stamp_next = stamp_q;
		case (phase_q)
			KEY_PRESS_WAIT: begin
				if (dt > {{(TimeW-CfgW){1'b0}}, cfg.press_confirm}) begin
					phase_next = level ? KEY_DOWN : KEY_IDLE;
				end
			end
			KEY_DOWN, KEY_LONG: begin
				if (!level) begin
					phase_next = KEY_REL_WAIT;
					stamp_next = now_ms;
				end else if (phase_q == KEY_DOWN &&
						dt > {{(TimeW-CfgW){1'b0}}, cfg.hold}) begin
					phase_next = KEY_LONG;
				end
			end
			KEY_REL_WAIT: begin
				if (dt > {{(TimeW-CfgW){1'b0}}, cfg.release_confirm}) begin
					phase_next = KEY_IDLE;
				end
			end
			default: begin
				// Released, and any code that means nothing.
				if (level) begin
					phase_next = KEY_PRESS_WAIT;
					stamp_next = now_ms;
				end else begin
					phase_next = KEY_IDLE;
				end
			end
		endcase
	end

	// Events on leaving the pressed phase, and whether the next phase is the pressed one.
	always_comb begin
		evt.pressed_next = (phase_next == KEY_DOWN);
		evt.short_press  = (phase_q == KEY_DOWN) && (phase_next == KEY_REL_WAIT);
		evt.long_hold    = (phase_q == KEY_DOWN) && (phase_next == KEY_LONG);
	end

	// Phase state, advanced once per word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= KEY_IDLE;
			stamp_q <= '0;
		end else if (step) begin
			phase_q <= phase_next;
			stamp_q <= stamp_next;
		end
	end

endmodule

`default_nettype wire

// File: sv/dkp_gate.sv
// Startup gate, startup lock and charge pin monitor.
`default_nettype none

module dkp_gate
	import dkp_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             step,
	input  wire logic [TimeW-1:0] now_ms,
	input  wire logic [CfgW-1:0]  startup_delay,
	input  wire logic             lower_pressed_next,
	input  wire logic             charge_level,
	output logic                  emit,
	output chg_status_t           charge_status,
	output logic                  pull_up_next
);

	logic [TimeW-1:0] origin_q;
	logic             captured_q;
	logic             lock_q;
	logic             chg_prev_q;
	logic             toggle_q;
	logic [TimeW-1:0] origin_eff;
	logic             gate_open;

	// The first word sets the origin, so its own elapsed time is zero.
	assign origin_eff = captured_q ? origin_q : now_ms;
	assign gate_open  = (now_ms - origin_eff) >= {{(TimeW-CfgW){1'b0}}, startup_delay};

	// Lock holds events back while the lower key sits pressed after startup.
	// The first word that gets through also clears the lock.
	assign emit = gate_open && !(lock_q && lower_pressed_next);

	// Charge pin status and pull for the next sample.
	always_comb begin
		if (charge_level != chg_prev_q) begin
			charge_status = CHG_CHANGING;
		end else if (charge_level) begin
			charge_status = CHG_STABLE_HIGH;
		end else begin
			charge_status = CHG_STABLE_LOW;
		end
		pull_up_next = toggle_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_q   <= '0;
			captured_q <= 1'b0;
			lock_q     <= 1'b1;
			chg_prev_q <= 1'b1;
			toggle_q   <= 1'b1;
		end else if (step) begin
			if (!captured_q) begin
				origin_q   <= now_ms;
				captured_q <= 1'b1;
			end
			if (emit) begin
				lock_q <= 1'b0;
			end
			chg_prev_q <= charge_level;
			toggle_q   <= ~toggle_q;
		end
	end

endmodule

`default_nettype wire

// File: sv/two_key_debounce_press_hold.sv
// Top level of the two-key debounce with press/hold events and charge monitor.
//
// Channel   Dir  Bits  Contents
// s_axis    in   40    lower_level, upper_level, charge_level, now_ms
// m_axis    out  8     four key events, activity, charge_status, pull_up_next
// cfg       in   16    press, release, hold and startup times
//
// A word is registered on input and its result is computed from the input register
// into the output register, from which it is offered on m_axis; one word per cycle
// is sustained while m_axis is ready.
// The key, gate and charge state advance when the input register moves a word
// into the output register. arst_n clears all control state and loads the
// register defaults. A stall on m_axis holds the output register; the input
// register still takes one more word, and then s_axis_tready drops.
`default_nettype none

module two_key_debounce_press_hold
	import dkp_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             s_axis_tvalid,
	output logic                  s_axis_tready,
	// [0] lower_level, [1] upper_level, [2] charge_level, [34:3] now_ms, [39:35] zero
	input  wire logic [InW-1:0]   s_axis_tdata,
	output logic                  m_axis_tvalid,
	input  wire logic             m_axis_tready,
	// [0] lower_short_press, [1] lower_long_hold, [2] upper_short_press,
	// [3] upper_long_hold, [4] activity, [6:5] charge_status, [7] pull_up_next
	output logic [OutW-1:0]       m_axis_tdata,
	input  wire logic             cfg_we,
	input  wire logic [1:0]       cfg_index,
	input  wire logic [CfgW-1:0]  cfg_data
);

	logic [CfgW-1:0]  press_confirm_q;
	logic [CfgW-1:0]  release_confirm_q;
	logic [CfgW-1:0]  hold_q;
	logic [CfgW-1:0]  startup_delay_q;
	key_cfg_t         key_cfg;

	logic             valid_s1;
	logic             lower_s1;
	logic             upper_s1;
	logic             charge_s1;
	logic [TimeW-1:0] now_s1;

	logic             out_free;
	logic             step;
	key_evt_t         lower_evt;
	key_evt_t         upper_evt;
	logic             emit;
	chg_status_t      charge_status;
	logic             pull_up_next;
	logic [3:0]       events;

	logic             valid_q;
	logic [OutW-1:0]  data_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			press_confirm_q   <= PressConfirmRst;
			release_confirm_q <= ReleaseConfirmRst;
			hold_q            <= HoldRst;
			startup_delay_q   <= StartupDelayRst;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_PRESS_CONFIRM:   press_confirm_q   <= cfg_data;
				REG_RELEASE_CONFIRM: release_confirm_q <= cfg_data;
				REG_HOLD:            hold_q            <= cfg_data;
				REG_STARTUP_DELAY:   startup_delay_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	assign key_cfg.press_confirm   = press_confirm_q;
	assign key_cfg.release_confirm = release_confirm_q;
	assign key_cfg.hold            = hold_q;

	// Handshake: a word moves on when the output register is empty or draining.
	assign out_free      = !valid_q || m_axis_tready;
	assign step          = valid_s1 && out_free;
	assign s_axis_tready = !valid_s1 || out_free;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			lower_s1  <= s_axis_tdata[0];
			upper_s1  <= s_axis_tdata[1];
			charge_s1 <= s_axis_tdata[2];
			now_s1    <= s_axis_tdata[3 +: TimeW];
		end
	end

	// Per-key machines.
	dkp_key u_lower (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.level  (lower_s1),
		.now_ms (now_s1),
		.cfg    (key_cfg),
		.evt    (lower_evt)
	);

	dkp_key u_upper (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.level  (upper_s1),
		.now_ms (now_s1),
		.cfg    (key_cfg),
		.evt    (upper_evt)
	);

	// Startup gating and charge monitor.
	dkp_gate u_gate (
		.clk                (clk),
		.arst_n             (arst_n),
		.step               (step),
		.now_ms             (now_s1),
		.startup_delay      (startup_delay_q),
		.lower_pressed_next (lower_evt.pressed_next),
		.charge_level       (charge_s1),
		.emit               (emit),
		.charge_status      (charge_status),
		.pull_up_next       (pull_up_next)
	);

	// Gated events, highest bit first.
	assign events = {4{emit}} & {upper_evt.long_hold, upper_evt.short_press,
		lower_evt.long_hold, lower_evt.short_press};

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (out_free) begin
			valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			data_q <= {pull_up_next, charge_status, |events, events};
		end
	end

	assign m_axis_tvalid = valid_q;
	assign m_axis_tdata  = data_q;

	// Checks.
	a_activity_matches: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[4] == |m_axis_tdata[3:0]))
		else $error("activity does not match the event bits");

	a_no_press_and_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[1]) &&
			!(m_axis_tdata[2] && m_axis_tdata[3]))
		else $error("short press and hold reported together for one key");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[6:5] != 2'd3))
		else $error("charge status carries an unused code");

	a_pull_alternates: assert property (@(posedge clk) disable iff (!arst_n)
		step ##1 step |-> (pull_up_next != $past(pull_up_next)))
		else $error("charge pull did not alternate between words");

	a_events_gated: assert property (@(posedge clk) disable iff (!arst_n)
		step && !emit |=> (data_q[4:0] == 5'd0))
		else $error("event reported while gated");

endmodule

`default_nettype wire

// File: dv/two_key_debounce_press_hold_tb.sv
// Self-checking testbench for the two-key debounce block with press/hold events.
`timescale 1ns / 100ps

module two_key_debounce_press_hold_tb;
	import dkp_pkg::*;

	// Layout of one result word, highest field first.
	typedef struct packed {
		logic        pull_up;
		chg_status_t charge;
		logic        activity;
		logic        upper_hold;
		logic        upper_short;
		logic        lower_hold;
		logic        lower_short;
	} report_t;

	localparam logic [TimeW-1:0] BootMs = 32'hFFFF_FF00;
	localparam int StallLimit = 2000;
	localparam int HoldOffCycles = 60;

	logic            clk = 1'b0;
	logic            arst_n = 1'b0;
	logic            s_axis_tvalid = 1'b0;
	logic            s_axis_tready;
	logic [InW-1:0]  s_axis_tdata = '0;
	logic            m_axis_tvalid;
	logic            m_axis_tready = 1'b0;
	logic [OutW-1:0] m_axis_tdata;
	logic            cfg_we = 1'b0;
	logic [1:0]      cfg_index = '0;
	logic [CfgW-1:0] cfg_data = '0;

	two_key_debounce_press_hold uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Timing settings as the block should hold them.
	logic [CfgW-1:0] cfg_press   = PressConfirmRst;
	logic [CfgW-1:0] cfg_release = ReleaseConfirmRst;
	logic [CfgW-1:0] cfg_hold    = HoldRst;
	logic [CfgW-1:0] cfg_startup = StartupDelayRst;

	// Key, startup gate and charge monitor state of the predictor.
	key_phase_t       key_phase [2] = '{KEY_IDLE, KEY_IDLE};
	logic [TimeW-1:0] key_stamp [2] = '{32'd0, 32'd0};
	logic [TimeW-1:0] origin_ms = '0;
	logic             origin_seen = 1'b0;
	logic             boot_lock = 1'b1;
	logic             charge_prev = 1'b1;
	logic             pull_toggle = 1'b1;

	logic [InW-1:0] sample_q [$];
	report_t        expected_reports [$];
	report_t        got_report;
	report_t        want_report;
	int             samples_sent = 0;
	int             reports_seen = 0;
	int             error_count = 0;
	int             idle_cycles = 0;
	int             holdoff_left = 0;
	logic           holdoff_done = 1'b0;

	// Random traffic generator state.
	logic [TimeW-1:0] stamp_ms;
	logic             lo_lvl = 1'b0;
	logic             up_lvl = 1'b0;
	logic             ch_lvl = 1'b1;
	int               lo_run = 0;
	int               up_run = 0;

	// One debounce step of a single key.
	function automatic void debounce_key(int k, logic level, logic [TimeW-1:0] now);
		logic [TimeW-1:0] dt;
		dt = now - key_stamp[k];
		case (key_phase[k])
			KEY_PRESS_WAIT: begin
				if (dt > TimeW'(cfg_press))
					key_phase[k] = level ? KEY_DOWN : KEY_IDLE;
			end
			KEY_DOWN, KEY_LONG: begin
				if (!level) begin
					key_phase[k] = KEY_REL_WAIT;
					key_stamp[k] = now;
				end else if (key_phase[k] == KEY_DOWN && dt > TimeW'(cfg_hold)) begin
					key_phase[k] = KEY_LONG;
				end
			end
			KEY_REL_WAIT: begin
				if (dt > TimeW'(cfg_release))
					key_phase[k] = KEY_IDLE;
			end
			default: begin
				if (level) begin
					key_phase[k] = KEY_PRESS_WAIT;
					key_stamp[k] = now;
				end else begin
					key_phase[k] = KEY_IDLE;
				end
			end
		endcase
	endfunction

	// Advances the predictor by one sample word and returns the expected report.
	function automatic report_t predict_sample(logic lo, logic up, logic ch,
			logic [TimeW-1:0] now);
		key_phase_t       lo_was;
		key_phase_t       up_was;
		logic [TimeW-1:0] since_boot;
		logic             gate_open;
		report_t          r;
		if (!origin_seen) begin
			origin_ms = now;
			origin_seen = 1'b1;
		end
		lo_was = key_phase[0];
		up_was = key_phase[1];
		debounce_key(0, lo, now);
		debounce_key(1, up, now);

		r = '0;
		r.pull_up = pull_toggle;
		pull_toggle = ~pull_toggle;
		if (ch != charge_prev)
			r.charge = CHG_CHANGING;
		else
			r.charge = ch ? CHG_STABLE_HIGH : CHG_STABLE_LOW;
		charge_prev = ch;

		// Events wait for the startup delay, then for the lower key to let go.
		since_boot = now - origin_ms;
		gate_open = since_boot >= TimeW'(cfg_startup);
		if (gate_open) begin
			if (boot_lock && key_phase[0] == KEY_DOWN)
				gate_open = 1'b0;
			else
				boot_lock = 1'b0;
		end
		if (gate_open) begin
			r.lower_short = lo_was == KEY_DOWN && key_phase[0] == KEY_REL_WAIT;
			r.lower_hold  = lo_was == KEY_DOWN && key_phase[0] == KEY_LONG;
			r.upper_short = up_was == KEY_DOWN && key_phase[1] == KEY_REL_WAIT;
			r.upper_hold  = up_was == KEY_DOWN && key_phase[1] == KEY_LONG;
		end
		r.activity = r.lower_short | r.lower_hold | r.upper_short | r.upper_hold;
		return r;
	endfunction

	function automatic void flag_error(string msg);
		if (error_count < 10)
			$display("%s", msg);
		error_count++;
	endfunction

	function automatic void check_report(report_t want, report_t got);
		string bad;
		bad = "";
		if (got.lower_short !== want.lower_short) bad = {bad, " lower_short_press"};
		if (got.lower_hold !== want.lower_hold)   bad = {bad, " lower_long_hold"};
		if (got.upper_short !== want.upper_short) bad = {bad, " upper_short_press"};
		if (got.upper_hold !== want.upper_hold)   bad = {bad, " upper_long_hold"};
		if (got.activity !== want.activity)       bad = {bad, " activity"};
		if (got.charge !== want.charge)           bad = {bad, " charge_status"};
		if (got.pull_up !== want.pull_up)         bad = {bad, " pull_up_next"};
		if (bad != "")
			flag_error($sformatf("report %0d mismatch in%s: expected %h, got %h",
				reports_seen, bad, want, got));
	endfunction

	function automatic void queue_sample(logic lo, logic up, logic ch, logic [TimeW-1:0] now);
		sample_q.push_back({5'b0, now, ch, up, lo});
	endfunction

	// Key levels come in runs of random length with occasional chatter; time mostly
	// moves forward in steps scaled to the hold time, and now and then jumps.
	task automatic queue_traffic(int count);
		int max_step;
		max_step = cfg_hold / 8 + 3;
		for (int i = 0; i < count; i++) begin
			if (lo_run == 0) begin
				lo_lvl = 1'($urandom_range(0, 1));
				lo_run = $urandom_range(1, 30);
			end
			if (up_run == 0) begin
				up_lvl = 1'($urandom_range(0, 1));
				up_run = $urandom_range(1, 30);
			end
			lo_run--;
			up_run--;
			if ($urandom_range(0, 3) == 0)
				ch_lvl = ~ch_lvl;
			case ($urandom_range(0, 39))
				0: stamp_ms = origin_ms + $urandom_range(0, cfg_startup);
				1: stamp_ms = $urandom();
				default: stamp_ms = stamp_ms + $urandom_range(0, max_step);
			endcase
			queue_sample(lo_lvl ^ ($urandom_range(0, 15) == 0),
				up_lvl ^ ($urandom_range(0, 15) == 0), ch_lvl, stamp_ms);
		end
	endtask

	// Returns once every word has been taken and every report has come back.
	task automatic wait_drained();
		while (sample_q.size() != 0 || s_axis_tvalid || expected_reports.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Writes all four timing registers back to back while the block is idle.
	task automatic set_regs(logic [CfgW-1:0] p_ms, logic [CfgW-1:0] r_ms,
			logic [CfgW-1:0] h_ms, logic [CfgW-1:0] s_ms);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= REG_PRESS_CONFIRM;
		cfg_data <= p_ms;
		@(posedge clk);
		cfg_index <= REG_RELEASE_CONFIRM;
		cfg_data <= r_ms;
		@(posedge clk);
		cfg_index <= REG_HOLD;
		cfg_data <= h_ms;
		@(posedge clk);
		cfg_index <= REG_STARTUP_DELAY;
		cfg_data <= s_ms;
		@(posedge clk);
		cfg_we <= 1'b0;
		cfg_press = p_ms;
		cfg_release = r_ms;
		cfg_hold = h_ms;
		cfg_startup = s_ms;
	endtask

	// Sender: predicts each accepted word and offers the next pending one.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				expected_reports.push_back(predict_sample(s_axis_tdata[0], s_axis_tdata[1],
					s_axis_tdata[2], s_axis_tdata[34:3]));
				samples_sent <= samples_sent + 1;
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (sample_q.size() != 0 && ((samples_sent >= 450 && samples_sent < 600)
						|| $urandom_range(0, 99) >= 16)) begin
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= sample_q.pop_front();
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// Receiver ready: random stalls, one long hold-off, and a stretch with none.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			holdoff_left <= 0;
			holdoff_done <= 1'b0;
		end else if (holdoff_left != 0) begin
			m_axis_tready <= 1'b0;
			holdoff_left <= holdoff_left - 1;
		end else if (!holdoff_done && reports_seen >= 200) begin
			m_axis_tready <= 1'b0;
			holdoff_left <= HoldOffCycles;
			holdoff_done <= 1'b1;
		end else begin
			m_axis_tready <= (reports_seen >= 450 && reports_seen < 600)
				|| $urandom_range(0, 99) >= 16;
		end
	end

	// Monitor: each report is checked against the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got_report = report_t'(m_axis_tdata);
			if (expected_reports.size() == 0) begin
				flag_error($sformatf("report %0d arrived with none expected: got %h",
					reports_seen, got_report));
			end else begin
				want_report = expected_reports.pop_front();
				check_report(want_report, got_report);
			end
			reports_seen <= reports_seen + 1;
		end
	end

	// Watchdog on cycles in which no word moves on either side.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= StallLimit) begin
				$display("RESULT: ERROR");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Startup gate with the lower key held, so the lock swallows the upper press.
		queue_sample(1'b1, 1'b0, 1'b1, BootMs);
		queue_sample(1'b1, 1'b0, 1'b1, BootMs + 60);
		queue_sample(1'b1, 1'b1, 1'b0, BootMs + 120);
		queue_sample(1'b1, 1'b1, 1'b0, BootMs + 200);
		queue_sample(1'b1, 1'b0, 1'b1, BootMs + 300);
		// Lower release clears the lock and gives a short press.
		queue_sample(1'b0, 1'b0, 1'b0, BootMs + 320);
		queue_sample(1'b0, 1'b0, 1'b1, BootMs + 380);
		// Upper press confirmed only once strictly past the confirm time, then hold.
		queue_sample(1'b0, 1'b1, 1'b1, BootMs + 400);
		queue_sample(1'b0, 1'b1, 1'b0, BootMs + 450);
		queue_sample(1'b0, 1'b1, 1'b0, BootMs + 451);
		queue_sample(1'b0, 1'b1, 1'b1, BootMs + 1300);
		queue_sample(1'b0, 1'b1, 1'b1, BootMs + 1301);
		queue_sample(1'b0, 1'b0, 1'b0, BootMs + 1400);
		queue_sample(1'b0, 1'b0, 1'b1, BootMs + 1451);
		// Both keys at once: lower hold and upper short press in one sample.
		queue_sample(1'b1, 1'b1, 1'b0, BootMs + 1500);
		queue_sample(1'b1, 1'b1, 1'b1, BootMs + 1600);
		queue_sample(1'b1, 1'b0, 1'b1, BootMs + 2401);
		queue_sample(1'b0, 1'b0, 1'b0, BootMs + 2402);
		// A press whose key is low again once its confirm window is past is dropped.
		queue_sample(1'b0, 1'b1, 1'b0, BootMs + 2500);
		queue_sample(1'b0, 1'b1, 1'b1, BootMs + 2501);
		queue_sample(1'b0, 1'b0, 1'b1, BootMs + 2600);
		// Time steps back across the wrap, through all ones and zero.
		queue_sample(1'b1, 1'b0, 1'b0, BootMs + 255);
		queue_sample(1'b1, 1'b0, 1'b0, BootMs + 256);
		queue_sample(1'b1, 1'b0, 1'b1, BootMs + 400);
		queue_sample(1'b0, 1'b0, 1'b0, BootMs + 5000);
		stamp_ms = BootMs + 5000;
		wait_drained();

		queue_traffic(130);
		wait_drained();

		set_regs(16'd0, 16'd0, 16'd0, 16'd0);
		queue_traffic(110);
		wait_drained();

		set_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		queue_traffic(110);
		wait_drained();

		for (int ph = 0; ph < 4; ph++) begin
			set_regs(16'($urandom_range(0, 200)), 16'($urandom_range(0, 200)),
				16'($urandom_range(0, 3000)), 16'($urandom_range(0, 2000)));
			queue_traffic(110);
			wait_drained();
		end

		repeat (8) @(posedge clk);
		if (error_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// File: files.f
sv/dkp_pkg.sv
sv/dkp_key.sv
sv/dkp_gate.sv
sv/two_key_debounce_press_hold.sv
dv/two_key_debounce_press_hold_tb.sv
